@@ rtl/core/salc_pkg.sv @@
package salc_pkg;

    localparam int TAG_W   = 64;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int LINE_W  = 1 + TAG_W + STAMP_W;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_WAYS       = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

    localparam logic [2:0] RST_SET_BITS   = 3'd4;
    localparam logic [3:0] RST_WAYS       = 4'd1;
    localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] address;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic             last;
        logic [CNT_W-1:0] hits_so_far;
        logic [CNT_W-1:0] misses_so_far;
        logic [CNT_W-1:0] evictions_so_far;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic read;
        logic look;
        logic pick;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/salc_ram.sv @@
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/core/salc_ctrl.sv @@
module salc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      req_type,
    output logic            s_ready,
    input  salc_pkg::stat_t stat,
    output salc_pkg::cmd_t  cmd
);
    import salc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_LOOK, ST_PICK
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg, first_next;

    always_comb begin
        state_next = state_reg;
        first_next = first_reg;
        cmd        = '0;
        cmd.last   = !first_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    first_next = (req_type == REQ_MODIFY);
                    if (req_type != REQ_NONE) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (stat.out_free) begin
                    cmd.pick = 1'b1;
                    if (first_reg) begin
                        first_next = 1'b0;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end
endmodule

@@ rtl/core/salc_dp.sv @@
module salc_dp #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  salc_pkg::cmd_t  cmd,
    output salc_pkg::stat_t stat,
    input  salc_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output salc_pkg::rsp_t  m_data,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);
    import salc_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W = MAX_WAYS * LINE_W;

    // configuration
    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] block_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= RST_SET_BITS;
            ways_reg       <= RST_WAYS;
            block_bits_reg <= RST_BLOCK_BITS;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                CFG_WAYS:       ways_reg       <= cfg_data[3:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [2:0] sb;
    logic [3:0] nw;
    // clamp limits compared at full width, the register fields are narrower
    assign sb = (int'(set_bits_reg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_reg;
    assign nw = (ways_reg == 4'd0) ? 4'd1
              : ((int'(ways_reg) > MAX_WAYS) ? 4'(MAX_WAYS) : ways_reg);

    // request and address split
    req_t             req_reg;
    logic [SET_W-1:0] set_idx;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_calc;
    logic [6:0]       tag_shift;
    logic [63:0]      shifted;

    always_comb begin
        shifted   = req_reg.address >> block_bits_reg;
        set_idx   = shifted[SET_W-1:0] & SET_W'((64'd1 << sb) - 64'd1);
        tag_shift = 7'(sb) + 7'(block_bits_reg);
        tag_calc  = (tag_shift >= 7'd64) ? '0 : (req_reg.address >> tag_shift);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
        if (cmd.read) begin
            set_reg <= set_idx;
            tag_reg <= tag_calc;
        end
    end

    // clear sweep
    logic [SET_W-1:0] clr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clear) begin
            clr_reg <= clr_reg + SET_W'(1);
        end
    end
    assign stat.clear_last = (clr_reg == SET_W'(SETS - 1));

    // set memory
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] row_wr;

    assign ram_we    = cmd.clear | cmd.pick;
    assign ram_waddr = cmd.clear ? clr_reg : set_reg;
    assign ram_wdata = cmd.clear ? '0 : row_wr;

    salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    // lookup: match or empty per way, and oldest stamp per way
    logic [STAMP_W-1:0] clock_reg;
    logic [STAMP_W-1:0] new_clk;
    assign new_clk = clock_reg + STAMP_W'(1);

    logic [MAX_WAYS-1:0] cand, found, oldest;
    logic [MAX_WAYS-1:0] found_reg, oldest_reg, valid_reg;
    logic [STAMP_W-1:0]  stamp_w [MAX_WAYS];

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            stamp_w[w] = ram_rdata[w*LINE_W +: STAMP_W];
            cand[w]    = (5'(w) < 5'(nw));
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            found[w]  = cand[w] & (!ram_rdata[w*LINE_W + LINE_W - 1]
                        | (ram_rdata[w*LINE_W + STAMP_W +: TAG_W] == tag_reg));
            oldest[w] = cand[w] & (stamp_w[w] < new_clk);
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (cand[j] && j < w && !(stamp_w[w] < stamp_w[j])) begin
                    oldest[w] = 1'b0;
                end
                if (cand[j] && j > w && (stamp_w[j] < stamp_w[w])) begin
                    oldest[w] = 1'b0;
                end
            end
        end
    end

    logic [ROW_W-1:0] row_reg;
    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            row_reg    <= ram_rdata;
            found_reg  <= found;
            oldest_reg <= oldest;
            for (int w = 0; w < MAX_WAYS; w++) begin
                valid_reg[w] <= ram_rdata[w*LINE_W + LINE_W - 1];
            end
        end
    end

    // pick victim and update
    logic [WAY_W-1:0] first_idx, old_idx, victim;
    logic             any_found, hit, evict;

    always_comb begin
        first_idx = '0;
        old_idx   = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (found_reg[w]) begin
                first_idx = WAY_W'(w);
            end
            if (oldest_reg[w]) begin
                old_idx = WAY_W'(w);
            end
        end
        any_found = |found_reg;
        hit       = any_found & valid_reg[first_idx];
        evict     = !any_found;
        victim    = any_found ? first_idx : old_idx;
        row_wr    = row_reg;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WAY_W'(w) == victim) begin
                row_wr[w*LINE_W +: LINE_W] = {1'b1, tag_reg, new_clk};
            end
        end
    end

    logic [CNT_W-1:0] hits_reg, misses_reg, evicts_reg;
    logic [CNT_W-1:0] hits_next, misses_next, evicts_next;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    always_comb begin
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        if (hit) begin
            if (hits_reg != CNT_MAX) hits_next = hits_reg + CNT_W'(1);
        end else begin
            if (misses_reg != CNT_MAX) misses_next = misses_reg + CNT_W'(1);
            if (evict && evicts_reg != CNT_MAX) evicts_next = evicts_reg + CNT_W'(1);
        end
    end

    logic m_valid_reg;
    rsp_t m_data_reg;
    assign stat.out_free = !m_valid_reg | m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg   <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            evicts_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.pick) begin
                clock_reg   <= new_clk;
                hits_reg    <= hits_next;
                misses_reg  <= misses_next;
                evicts_reg  <= evicts_next;
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pick) begin
            m_data_reg.hit              <= hit;
            m_data_reg.evicted          <= evict;
            m_data_reg.last             <= cmd.last;
            m_data_reg.hits_so_far      <= hits_next;
            m_data_reg.misses_so_far    <= misses_next;
            m_data_reg.evictions_so_far <= evicts_next;
        end
    end
endmodule

@@ rtl/core/set_assoc_lru_cache_model.sv @@
// tag-only set-associative cache with lru replacement
// input channel s_*: one transfer carries req_type and address; load and
//   store give one result, modify gives two, code 3 gives none
// result channel m_*: hit, evicted, last and the three running totals;
//   last marks the final result of an input transfer
// config channel cfg_*: index 0 set_bits, 1 ways, 2 block_bits; always
//   ready, write only while the block is idle
// order: the request is registered, the set row is read, the lookup result
//   is registered, then the result register is written at the pick; a modify
//   repeats read, lookup and pick; no new input is taken before the last pick,
//   and each pick writes back one set row of the set memory
// reset: totals, clock and config return to defaults, then a clearing
//   pass zeroes all 2**MAX_SET_BITS rows of the set memory; no input is
//   taken during it
// stall: one output register; a new input is taken while a result waits,
//   the next result is held back until the waiting one is transferred
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  salc_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output salc_pkg::rsp_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data
);
    import salc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // config writes need no wait
    assign cfg_ready = 1'b1;

    // sequencer
    salc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_data.req_type),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // set memory, lookup, victim choice and totals
    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );
endmodule

@@ rtl/core/salc_checker.sv @@
module salc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input salc_pkg::rsp_t m_data,
    input logic           m_valid,
    input logic           m_ready
);
    import salc_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed under stall");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> !m_data.evicted)
        else $error("hit with eviction");

    // a hit result shows a nonzero hit total
    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> m_data.hits_so_far != '0)
        else $error("hit total zero on hit");

    // no result and no input ready right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity after reset");
endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
